### sv/bankers_safety_and_request_core_macros.svh
// Assertion macros for the banker's safety and request core.
`ifndef BANKERS_SAFETY_AND_REQUEST_CORE_MACROS_SVH
`define BANKERS_SAFETY_AND_REQUEST_CORE_MACROS_SVH

// Combinational invariant, sampled on every rising clock edge out of reset.
`define BSR_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Antecedent in this cycle implies consequent in the next.
`define BSR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/bsr_pkg.sv
// Shared types, codes and helper functions for the banker's safety and request core.
package bsr_pkg;

   localparam int DEF_MAX_PROCS = 8;
   localparam int DEF_MAX_RES   = 8;
   localparam int VAL_W         = 16;
   localparam int CNT_REG_W     = 4;

   localparam logic [CNT_REG_W-1:0] CNT_REG_RESET = 4'd8;

   // command codes
   localparam logic [2:0] CMD_LOAD_ALLOC = 3'd0;
   localparam logic [2:0] CMD_LOAD_MAX   = 3'd1;
   localparam logic [2:0] CMD_LOAD_AVAIL = 3'd2;
   localparam logic [2:0] CMD_CHECK      = 3'd3;
   localparam logic [2:0] CMD_REQUEST    = 3'd4;

   // result kinds
   localparam logic [2:0] KIND_SAFE      = 3'd0;
   localparam logic [2:0] KIND_UNSAFE    = 3'd1;
   localparam logic [2:0] KIND_GRANTED   = 3'd2;
   localparam logic [2:0] KIND_EXCEEDS   = 3'd3;
   localparam logic [2:0] KIND_NOT_AVAIL = 3'd4;

   // configuration register indexes
   localparam logic CSR_NUM_PROCESSES = 1'b0;
   localparam logic CSR_NUM_RESOURCES = 1'b1;

   typedef struct packed {
      logic [2:0]       cmd;
      logic [2:0]       proc_index;
      logic [2:0]       res_index;
      logic [VAL_W-1:0] value;
      logic             last_element;
   } bsr_req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] proc_out;
      logic       last_out;
   } bsr_rsp_type;

   typedef struct packed {
      logic        valid;
      bsr_rsp_type data;
   } bsr_emit_type;

   function automatic int idx_w(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

   // zero acts as one, anything above top acts as top; returns count minus one
   function automatic int clamp_last(input logic [CNT_REG_W-1:0] v, input int top);
      int c;
      c = int'(v);
      if (c == 0) begin
         c = 1;
      end else if (c > top) begin
         c = top;
      end
      return c - 1;
   endfunction

endpackage

### sv/bsr_alu.sv
// Shared compare and add unit: need against an operand, operand plus allocation.
module bsr_alu #(
   parameter int WW = 20
) (
   input  logic [bsr_pkg::VAL_W-1:0] max_val,
   input  logic [bsr_pkg::VAL_W-1:0] alloc_val,
   input  logic [WW-1:0]             opnd,
   output logic                      need_gt_opnd,
   output logic                      opnd_gt_need,
   output logic [WW-1:0]             sum
);
   import bsr_pkg::*;

   logic [VAL_W:0]  need;
   logic [WW-1:0]   need_mag;

   assign need         = {1'b0, max_val} - {1'b0, alloc_val};
   assign need_mag     = WW'(need[VAL_W-1:0]);
   assign need_gt_opnd = !need[VAL_W] && (need_mag > opnd);
   assign opnd_gt_need = need[VAL_W] || (opnd > need_mag);
   assign sum          = opnd + WW'(alloc_val);

endmodule

### sv/bsr_engine.sv
// Sequencer, tables and vectors of the banker's core around one shared compare/add unit.
module bsr_engine #(
   parameter int MAX_PROCS = bsr_pkg::DEF_MAX_PROCS,
   parameter int MAX_RES   = bsr_pkg::DEF_MAX_RES,
   localparam int PW = bsr_pkg::idx_w(MAX_PROCS),
   localparam int RW = bsr_pkg::idx_w(MAX_RES)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  bsr_pkg::bsr_req_type   req,
   output logic                   idle,
   input  logic [PW-1:0]          np_m1,
   input  logic [RW-1:0]          nr_m1,
   output bsr_pkg::bsr_emit_type  emit,
   input  logic                   take
);
   import bsr_pkg::*;

   localparam int WW    = VAL_W + $clog2(MAX_PROCS + 1);
   localparam int CW    = $clog2(MAX_PROCS + 1);
   localparam int AW    = PW + RW;
   localparam int DEPTH = 1 << AW;

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_CK_RD   = 4'd2;
   localparam logic [3:0] S_CK_EV   = 4'd3;
   localparam logic [3:0] S_CK_ARD  = 4'd4;
   localparam logic [3:0] S_CK_AEV  = 4'd5;
   localparam logic [3:0] S_SEQ_OUT = 4'd6;
   localparam logic [3:0] S_ONE_OUT = 4'd7;
   localparam logic [3:0] S_RQ_RD   = 4'd8;
   localparam logic [3:0] S_RQ_EV   = 4'd9;
   localparam logic [3:0] S_RA_RD   = 4'd10;
   localparam logic [3:0] S_RA_EV   = 4'd11;

   logic [3:0]       state_ff, state_in;
   logic [PW-1:0]    i_ff, i_in;
   logic [RW-1:0]    j_ff, j_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [PW-1:0]    k_ff, k_in;
   logic             prog_ff, prog_in;
   logic [2:0]       kind_ff, kind_in;
   logic [PW-1:0]    rp_ff, rp_in;
   logic [AW-1:0]    clr_ff, clr_in;

   logic             fin_ff   [MAX_PROCS];
   logic             fin_in   [MAX_PROCS];
   logic [PW-1:0]    seq_ff   [MAX_PROCS];
   logic [PW-1:0]    seq_in   [MAX_PROCS];
   logic [WW-1:0]    work_ff  [MAX_RES];
   logic [WW-1:0]    work_in  [MAX_RES];
   logic [VAL_W-1:0] avail_ff [MAX_RES];
   logic [VAL_W-1:0] avail_in [MAX_RES];
   logic [VAL_W-1:0] rbuf_ff  [MAX_RES];
   logic [VAL_W-1:0] rbuf_in  [MAX_RES];

   logic [VAL_W-1:0] alloc_mem_ff [DEPTH];
   logic [VAL_W-1:0] max_mem_ff   [DEPTH];
   logic [VAL_W-1:0] alloc_rd_ff, max_rd_ff;

   logic             alloc_we, max_we;
   logic [AW-1:0]    mem_waddr, mem_raddr;
   logic [VAL_W-1:0] mem_wdata;

   logic             in_request;
   logic [WW-1:0]    alu_opnd, alu_sum;
   logic             need_gt_opnd, opnd_gt_need;

   assign in_request = (state_ff == S_RQ_RD) || (state_ff == S_RQ_EV) ||
                       (state_ff == S_RA_RD) || (state_ff == S_RA_EV);
   assign mem_raddr  = in_request ? {rp_ff, j_ff} : {i_ff, j_ff};
   assign alu_opnd   = in_request ? WW'(rbuf_ff[j_ff]) : work_ff[j_ff];
   assign idle       = (state_ff == S_IDLE);

   bsr_alu #(
      .WW(WW)
   ) u_alu (
      .max_val      (max_rd_ff),
      .alloc_val    (alloc_rd_ff),
      .opnd         (alu_opnd),
      .need_gt_opnd (need_gt_opnd),
      .opnd_gt_need (opnd_gt_need),
      .sum          (alu_sum)
   );

   always_comb begin
      logic          adv;
      logic          clr_rbuf;
      logic [CW-1:0] cnt_v;
      logic          prog_v;

      adv       = 1'b0;
      clr_rbuf  = 1'b0;
      cnt_v     = cnt_ff;
      prog_v    = prog_ff;
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      cnt_in    = cnt_ff;
      k_in      = k_ff;
      prog_in   = prog_ff;
      kind_in   = kind_ff;
      rp_in     = rp_ff;
      clr_in    = clr_ff;
      fin_in    = fin_ff;
      seq_in    = seq_ff;
      work_in   = work_ff;
      avail_in  = avail_ff;
      rbuf_in   = rbuf_ff;
      alloc_we  = 1'b0;
      max_we    = 1'b0;
      mem_waddr = {AW{1'b0}};
      mem_wdata = {VAL_W{1'b0}};
      emit      = '0;

      unique case (state_ff)
         S_CLEAR: begin
            alloc_we  = 1'b1;
            max_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == {AW{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               unique case (req.cmd)
                  CMD_LOAD_ALLOC, CMD_LOAD_MAX: begin
                     if (int'(req.proc_index) < MAX_PROCS && int'(req.res_index) < MAX_RES) begin
                        alloc_we = (req.cmd == CMD_LOAD_ALLOC);
                        max_we   = (req.cmd == CMD_LOAD_MAX);
                     end
                     mem_waddr = {PW'(req.proc_index), RW'(req.res_index)};
                     mem_wdata = req.value;
                  end
                  CMD_LOAD_AVAIL: begin
                     if (int'(req.res_index) < MAX_RES) begin
                        avail_in[RW'(req.res_index)] = req.value;
                     end
                  end
                  CMD_CHECK: begin
                     for (int n = 0; n < MAX_RES; n++) begin
                        work_in[n] = WW'(avail_ff[n]);
                     end
                     for (int n = 0; n < MAX_PROCS; n++) begin
                        fin_in[n] = 1'b0;
                     end
                     cnt_in   = {CW{1'b0}};
                     i_in     = {PW{1'b0}};
                     j_in     = {RW{1'b0}};
                     prog_in  = 1'b0;
                     state_in = S_CK_RD;
                  end
                  CMD_REQUEST: begin
                     if (int'(req.res_index) < MAX_RES) begin
                        rbuf_in[RW'(req.res_index)] = req.value;
                     end
                     if (req.last_element) begin
                        rp_in = PW'(req.proc_index);
                        j_in  = {RW{1'b0}};
                        if (int'(req.proc_index) >= MAX_PROCS) begin
                           kind_in  = KIND_EXCEEDS;
                           clr_rbuf = 1'b1;
                           state_in = S_ONE_OUT;
                        end else begin
                           state_in = S_RQ_RD;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CK_RD: begin
            if (fin_ff[i_ff]) begin
               adv = 1'b1;
            end else begin
               state_in = S_CK_EV;
            end
         end
         S_CK_EV: begin
            if (need_gt_opnd) begin
               adv = 1'b1;
            end else if (j_ff == nr_m1) begin
               j_in     = {RW{1'b0}};
               state_in = S_CK_ARD;
            end else begin
               j_in     = j_ff + RW'(1);
               state_in = S_CK_RD;
            end
         end
         S_CK_ARD: begin
            state_in = S_CK_AEV;
         end
         S_CK_AEV: begin
            work_in[j_ff] = alu_sum;
            if (j_ff == nr_m1) begin
               seq_in[cnt_ff[PW-1:0]] = i_ff;
               fin_in[i_ff]           = 1'b1;
               cnt_v                  = cnt_ff + CW'(1);
               prog_v                 = 1'b1;
               adv                    = 1'b1;
            end else begin
               j_in     = j_ff + RW'(1);
               state_in = S_CK_ARD;
            end
         end
         S_SEQ_OUT: begin
            emit.valid         = 1'b1;
            emit.data.kind     = KIND_SAFE;
            emit.data.proc_out = 3'(seq_ff[k_ff]);
            emit.data.last_out = (k_ff == np_m1);
            if (take) begin
               if (k_ff == np_m1) begin
                  state_in = S_IDLE;
               end else begin
                  k_in = k_ff + PW'(1);
               end
            end
         end
         S_ONE_OUT: begin
            emit.valid         = 1'b1;
            emit.data.kind     = kind_ff;
            emit.data.proc_out = 3'd0;
            emit.data.last_out = 1'b1;
            if (take) begin
               state_in = S_IDLE;
            end
         end
         S_RQ_RD: begin
            state_in = S_RQ_EV;
         end
         S_RQ_EV: begin
            if (opnd_gt_need) begin
               kind_in  = KIND_EXCEEDS;
               clr_rbuf = 1'b1;
               state_in = S_ONE_OUT;
            end else if (rbuf_ff[j_ff] > avail_ff[j_ff]) begin
               kind_in  = KIND_NOT_AVAIL;
               clr_rbuf = 1'b1;
               state_in = S_ONE_OUT;
            end else if (j_ff == nr_m1) begin
               j_in     = {RW{1'b0}};
               state_in = S_RA_RD;
            end else begin
               j_in     = j_ff + RW'(1);
               state_in = S_RQ_RD;
            end
         end
         S_RA_RD: begin
            state_in = S_RA_EV;
         end
         S_RA_EV: begin
            alloc_we       = 1'b1;
            mem_waddr      = {rp_ff, j_ff};
            mem_wdata      = alu_sum[VAL_W-1:0];
            avail_in[j_ff] = avail_ff[j_ff] - rbuf_ff[j_ff];
            if (j_ff == nr_m1) begin
               kind_in  = KIND_GRANTED;
               clr_rbuf = 1'b1;
               state_in = S_ONE_OUT;
            end else begin
               j_in     = j_ff + RW'(1);
               state_in = S_RA_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // end of one process in a safety pass
      if (adv) begin
         j_in    = {RW{1'b0}};
         cnt_in  = cnt_v;
         prog_in = prog_v;
         if (i_ff == np_m1) begin
            if (cnt_v == CW'(np_m1) + CW'(1)) begin
               k_in     = {PW{1'b0}};
               state_in = S_SEQ_OUT;
            end else if (!prog_v) begin
               kind_in  = KIND_UNSAFE;
               state_in = S_ONE_OUT;
            end else begin
               i_in     = {PW{1'b0}};
               prog_in  = 1'b0;
               state_in = S_CK_RD;
            end
         end else begin
            i_in     = i_ff + PW'(1);
            state_in = S_CK_RD;
         end
      end

      if (clr_rbuf) begin
         for (int n = 0; n < MAX_RES; n++) begin
            rbuf_in[n] = {VAL_W{1'b0}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         i_ff     <= {PW{1'b0}};
         j_ff     <= {RW{1'b0}};
         cnt_ff   <= {CW{1'b0}};
         k_ff     <= {PW{1'b0}};
         prog_ff  <= 1'b0;
         kind_ff  <= KIND_SAFE;
         rp_ff    <= {PW{1'b0}};
         clr_ff   <= {AW{1'b0}};
         for (int n = 0; n < MAX_PROCS; n++) begin
            fin_ff[n] <= 1'b0;
         end
         for (int n = 0; n < MAX_RES; n++) begin
            work_ff[n]  <= {WW{1'b0}};
            avail_ff[n] <= {VAL_W{1'b0}};
            rbuf_ff[n]  <= {VAL_W{1'b0}};
         end
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         cnt_ff   <= cnt_in;
         k_ff     <= k_in;
         prog_ff  <= prog_in;
         kind_ff  <= kind_in;
         rp_ff    <= rp_in;
         clr_ff   <= clr_in;
         fin_ff   <= fin_in;
         work_ff  <= work_in;
         avail_ff <= avail_in;
         rbuf_ff  <= rbuf_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff <= seq_in;
   end

   always_ff @(posedge clock) begin
      if (alloc_we) begin
         alloc_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (max_we) begin
         max_mem_ff[mem_waddr] <= mem_wdata;
      end
      alloc_rd_ff <= alloc_mem_ff[mem_raddr];
      max_rd_ff   <= max_mem_ff[mem_raddr];
   end

endmodule

### sv/bankers_safety_and_request_core.sv
// Top level of the banker's safety and request core: ports, registers, result buffer.
// Loads, available writes and non-final request elements are taken in the idle state and
// leave it idle. A safety check reads and compares each need, then reads and adds each
// allocation into the work vector, through one shared compare/add unit and the single read
// port of the allocation and maximum tables, in at most np passes before the result beats.
// A final request element checks each resource, then updates each, before its one
// result. After reset the tables are cleared entry by entry before the first item.
// A pending result waits in an output register while the next item is taken.
module bankers_safety_and_request_core #(
   parameter int MAX_PROCS = bsr_pkg::DEF_MAX_PROCS,
   parameter int MAX_RES   = bsr_pkg::DEF_MAX_RES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bsr_pkg::bsr_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bsr_pkg::bsr_rsp_type                rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_index,
   input  logic [bsr_pkg::CNT_REG_W-1:0]       csr_data
);
   import bsr_pkg::*;

   `include "bankers_safety_and_request_core_macros.svh"

   localparam int PW = idx_w(MAX_PROCS);
   localparam int RW = idx_w(MAX_RES);

   logic [CNT_REG_W-1:0] np_ff, np_in;
   logic [CNT_REG_W-1:0] nr_ff, nr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   bsr_rsp_type          rsp_data_ff, rsp_data_in;

   logic [PW-1:0]        np_m1;
   logic [RW-1:0]        nr_m1;
   logic                 eng_idle;
   logic                 take;
   bsr_emit_type         emit;

   assign np_m1     = PW'(clamp_last(np_ff, MAX_PROCS));
   assign nr_m1     = RW'(clamp_last(nr_ff, MAX_RES));
   assign req_ready = eng_idle;
   assign csr_ready = 1'b1;
   assign take      = emit.valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   bsr_engine #(
      .MAX_PROCS(MAX_PROCS),
      .MAX_RES  (MAX_RES)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .start (req_valid && req_ready),
      .req   (req_data),
      .idle  (eng_idle),
      .np_m1 (np_m1),
      .nr_m1 (nr_m1),
      .emit  (emit),
      .take  (take)
   );

   always_comb begin
      np_in = np_ff;
      nr_in = nr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_NUM_PROCESSES: np_in = csr_data;
            CSR_NUM_RESOURCES: nr_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      priority if (take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit.data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         np_ff        <= CNT_REG_RESET;
         nr_ff        <= CNT_REG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         np_ff        <= np_in;
         nr_ff        <= nr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   `BSR_ASSERT_ALWAYS(a_no_accept_while_emitting, !(req_ready && emit.valid), "item taken while results still owed")
   `BSR_ASSERT_NEXT(a_check_holds_off_input, req_valid && req_ready && req_data.cmd == CMD_CHECK, !req_ready, "ready after check start")
   `BSR_ASSERT_ALWAYS(a_single_result_shape, !rsp_valid || rsp_data.kind == KIND_SAFE || (rsp_data.proc_out == 3'd0 && rsp_data.last_out), "non-sequence beat malformed")

endmodule
